@@ rtl/core/ibtm_pkg.sv @@
`default_nettype none
package ibtm_pkg;

  localparam int AXES = 6;

  // reciprocal scaling for the mean divide, covers divisors up to 64
  localparam int RECIP_SH = 6;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] mean_accel_x;
    logic signed [15:0] mean_accel_y;
    logic signed [15:0] mean_accel_z;
    logic signed [15:0] mean_gyro_x;
    logic signed [15:0] mean_gyro_y;
    logic signed [15:0] mean_gyro_z;
  } out_t;

  // rank scan control, shared by all lanes
  typedef struct packed {
    logic valid;
    logic clear;
    logic first_j;
    logic last_j;
    logic j_lt_i;
    logic use_abs;
  } scan_ctl_t;

  typedef enum logic [2:0] {
    S_IN,
    S_SCAN,
    S_DRAIN,
    S_DSTART,
    S_DIV,
    S_WAIT
  } state_t;

  localparam logic KIND_CAL  = 1'b0;
  localparam logic KIND_MEAS = 1'b1;

endpackage
`default_nettype wire

@@ rtl/core/imu_bias_trimmed_mean.sv @@
// imu bias correction with interquartile trimmed mean, six axes
//
// input channel (in_valid/in_ready/in_data) takes one six-axis sample per
// transfer. each axis is bias corrected toward zero and written to its lane's
// window ram. the transfer that fills a window starts the evaluation:
//   rank scan: every lane ranks each sample against all others through a
//   two-port read of its ram (ties broken by index)
//   divide: one shared reciprocal multiplier; per axis it loads the sum's
//   magnitude, then multiplies and stores the quotient
// the result register (out_valid/out_data) loads after the divide. in_ready
// is low from the filling transfer until it loads; otherwise the block takes
// samples as in_valid offers them. the block accepts the next
// window's samples while the result waits. if the receiver still holds the
// previous result when a new one is ready, the block waits with in_ready low.
// the first window (CAL_WINDOW samples) averages absolute values and loads
// the biases, result_kind 0; later windows (MEAS_WINDOW) give result_kind 1.
// reset (rst, synchronous) clears biases, sample count and calibration;
// ram contents need no clearing since each entry is written before read.
`default_nettype none
module imu_bias_trimmed_mean #(
  parameter int CAL_WINDOW  = 16,
  parameter int MEAS_WINDOW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ibtm_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ibtm_pkg::out_t     out_data
);
  localparam int WIN_MAX = (CAL_WINDOW > MEAS_WINDOW) ? CAL_WINDOW : MEAS_WINDOW;
  localparam int AW = $clog2(WIN_MAX);
  localparam int CW = $clog2(WIN_MAX + 1);
  localparam int SW = 17 + AW;
  localparam int MW = SW - 1 + ibtm_pkg::RECIP_SH;
  // per-phase trim bounds and divisor
  localparam int CAL_Q    = CAL_WINDOW / 4;
  localparam int MEAS_Q   = MEAS_WINDOW / 4;
  localparam int CAL_CNT  = CAL_WINDOW - 2 * CAL_Q;
  localparam int MEAS_CNT = MEAS_WINDOW - 2 * MEAS_Q;
  // rounded-up reciprocals, exact for every sum magnitude the lanes produce
  localparam longint CAL_RECIP =
    ((longint'(1) << MW) + longint'(CAL_CNT) - longint'(1)) / longint'(CAL_CNT);
  localparam longint MEAS_RECIP =
    ((longint'(1) << MW) + longint'(MEAS_CNT) - longint'(1)) / longint'(MEAS_CNT);

  ibtm_pkg::state_t state, state_next;
  logic          calibrated;
  logic [15:0]   bias [ibtm_pkg::AXES];
  logic [AW-1:0] sample_count;
  logic [AW-1:0] si, sj;
  logic [AW-1:0] num_m1;
  logic [CW-1:0] rank_lo, rank_hi;
  logic [MW-1:0] recip;
  logic          accept, last_sample, scan_last;
  logic          div_start, div_done, load_out;
  ibtm_pkg::scan_ctl_t ctl;
  logic signed [15:0]  raw_ax [ibtm_pkg::AXES];
  logic [15:0]         bias_ax [ibtm_pkg::AXES];
  logic signed [SW-1:0] sums [ibtm_pkg::AXES];
  logic [15:0]          quo [ibtm_pkg::AXES];

  assign num_m1  = calibrated ? AW'(MEAS_WINDOW - 1) : AW'(CAL_WINDOW - 1);
  assign rank_lo = calibrated ? CW'(MEAS_Q) : CW'(CAL_Q);
  assign rank_hi = calibrated ? CW'(MEAS_WINDOW - MEAS_Q - 1) : CW'(CAL_WINDOW - CAL_Q - 1);
  assign recip   = calibrated ? MW'(MEAS_RECIP) : MW'(CAL_RECIP);

  assign in_ready    = (state == ibtm_pkg::S_IN);
  assign accept      = in_valid && in_ready;
  assign last_sample = (sample_count == num_m1);
  assign scan_last   = (si == num_m1) && (sj == num_m1);

  assign raw_ax[0] = in_data.accel_x;
  assign raw_ax[1] = in_data.accel_y;
  assign raw_ax[2] = in_data.accel_z;
  assign raw_ax[3] = in_data.gyro_x;
  assign raw_ax[4] = in_data.gyro_y;
  assign raw_ax[5] = in_data.gyro_z;

  // z accel bias counts four times
  always_comb begin
    for (int a = 0; a < ibtm_pkg::AXES; a++) bias_ax[a] = bias[a];
    bias_ax[2] = {bias[2][13:0], 2'b00};
  end

  // scan control for the lanes
  always_comb begin
    ctl.valid   = (state == ibtm_pkg::S_SCAN);
    ctl.clear   = (si == '0);
    ctl.first_j = (sj == '0);
    ctl.last_j  = (sj == num_m1);
    ctl.j_lt_i  = (sj < si);
    ctl.use_abs = !calibrated;
  end

  for (genvar a = 0; a < ibtm_pkg::AXES; a++) begin : g_lane
    ibtm_lane #(.WIN_MAX(WIN_MAX), .AW(AW), .CW(CW), .SW(SW)) u_lane (
      .clk(clk), .rst(rst), .wr_en(accept), .wr_addr(sample_count),
      .raw(raw_ax[a]), .bias(bias_ax[a]), .ctl(ctl), .rd_i(si), .rd_j(sj),
      .rank_lo(rank_lo), .rank_hi(rank_hi), .sum(sums[a])
    );
  end

  ibtm_div #(.SW(SW), .MW(MW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .recip(recip),
    .sums(sums), .done(div_done), .quo(quo)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ibtm_pkg::S_IN:     if (accept && last_sample) state_next = ibtm_pkg::S_SCAN;
      ibtm_pkg::S_SCAN:   if (scan_last) state_next = ibtm_pkg::S_DRAIN;
      ibtm_pkg::S_DRAIN:  state_next = ibtm_pkg::S_DSTART;
      ibtm_pkg::S_DSTART: begin
        div_start  = 1'b1;
        state_next = ibtm_pkg::S_DIV;
      end
      ibtm_pkg::S_DIV:    if (div_done) state_next = ibtm_pkg::S_WAIT;
      ibtm_pkg::S_WAIT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ibtm_pkg::S_IN;
        end
      end
      default:            state_next = ibtm_pkg::S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ibtm_pkg::S_IN;
    end else begin
      state <= state_next;
    end
  end

  // sample counter and scan indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      si <= '0;
      sj <= '0;
    end else begin
      if (accept) sample_count <= last_sample ? '0 : sample_count + 1'b1;
      if (state == ibtm_pkg::S_SCAN) begin
        if (sj == num_m1) begin
          sj <= '0;
          si <= (si == num_m1) ? '0 : si + 1'b1;
        end else begin
          sj <= sj + 1'b1;
        end
      end
    end
  end

  // result register, biases and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      calibrated <= 1'b0;
      for (int a = 0; a < ibtm_pkg::AXES; a++) bias[a] <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        out_data.result_kind  <= calibrated ? ibtm_pkg::KIND_MEAS : ibtm_pkg::KIND_CAL;
        out_data.mean_accel_x <= quo[0];
        out_data.mean_accel_y <= quo[1];
        out_data.mean_accel_z <= quo[2];
        out_data.mean_gyro_x  <= quo[3];
        out_data.mean_gyro_y  <= quo[4];
        out_data.mean_gyro_z  <= quo[5];
        if (!calibrated) begin
          calibrated <= 1'b1;
          for (int a = 0; a < ibtm_pkg::AXES; a++) bias[a] <= quo[a];
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ibtm_pkg::S_DIV)
    else $error("divider finished outside divide phase");
  a_window_stops_input: assert property (@(posedge clk) disable iff (rst)
    (accept && last_sample) |=> !in_ready)
    else $error("input taken right after window filled");
  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    sample_count <= num_m1)
    else $error("sample count beyond window");
  a_load_keeps_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load_out)
    else $error("pending result overwritten");
endmodule
`default_nettype wire

@@ rtl/core/ibtm_ram.sv @@
`default_nettype none
module ibtm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

@@ rtl/core/ibtm_lane.sv @@
`default_nettype none
module ibtm_lane #(
  parameter int WIN_MAX = 16,
  parameter int AW = 4,
  parameter int CW = 5,
  parameter int SW = 21
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic signed [15:0]   raw,
  input  wire logic [15:0]          bias,
  input  wire ibtm_pkg::scan_ctl_t  ctl,
  input  wire logic [AW-1:0]        rd_i,
  input  wire logic [AW-1:0]        rd_j,
  input  wire logic [CW-1:0]        rank_lo,
  input  wire logic [CW-1:0]        rank_hi,
  output logic signed [SW-1:0]      sum
);
  logic [15:0] corr;
  logic [15:0] va, vb;
  ibtm_pkg::scan_ctl_t ctl_d;
  logic [CW-1:0] rank;
  logic [CW-1:0] rank_next;
  logic          less;
  logic signed [SW-1:0] va_ext;
  logic signed [SW-1:0] va_term;

  // toward zero: negative gets bias added, others subtracted
  assign corr = raw[15] ? (raw + bias) : (raw - bias);

  ibtm_ram #(.WIDTH(16), .DEPTH(WIN_MAX)) u_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(corr),
    .raddr_a(rd_i), .raddr_b(rd_j), .rdata_a(va), .rdata_b(vb)
  );

  // j sorts before i: smaller, or equal with lower index
  assign less = ($signed(vb) < $signed(va)) || ((vb == va) && ctl_d.j_lt_i);
  assign rank_next = (ctl_d.first_j ? '0 : rank) + CW'(less);
  assign va_ext = SW'($signed(va));
  assign va_term = (ctl_d.use_abs && va[15]) ? -va_ext : va_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d <= '0;
    end else begin
      ctl_d <= ctl;
    end
    if (ctl_d.valid) begin
      rank <= rank_next;
      if (ctl_d.last_j) begin
        if (rank_next >= rank_lo && rank_next <= rank_hi)
          sum <= (ctl_d.clear ? '0 : sum) + va_term;
        else if (ctl_d.clear)
          sum <= '0;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/ibtm_div.sv @@
`default_nettype none
module ibtm_div #(
  parameter int SW = 21,
  parameter int MW = 26
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [MW-1:0]         recip,
  input  wire logic signed [SW-1:0]  sums [ibtm_pkg::AXES],
  output logic                       done,
  output logic [15:0]                quo [ibtm_pkg::AXES]
);
  localparam int NW = SW - 1;
  localparam int PW = NW + MW;

  logic          busy, ld, neg;
  logic [2:0]    axis;
  logic [NW-1:0] mag;
  logic [PW-1:0] prod;
  logic [15:0]   qlow;
  logic [15:0]   fin;

  // magnitude times rounded-up reciprocal, quotient sits at bit MW and up
  assign prod = PW'(mag) * PW'(recip);
  assign qlow = prod[MW +: 16];
  assign fin  = neg ? (16'd0 - qlow) : qlow;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ld   <= 1'b0;
      axis <= '0;
    end else begin
      done <= busy && !ld && (axis == 3'(ibtm_pkg::AXES - 1));
      if (start) begin
        busy <= 1'b1;
        axis <= '0;
        ld   <= 1'b1;
      end else if (busy) begin
        if (ld) begin
          neg <= sums[axis][SW-1];
          mag <= sums[axis][SW-1] ? NW'(-sums[axis]) : NW'(sums[axis]);
          ld  <= 1'b0;
        end else begin
          quo[axis] <= fin;
          if (axis == 3'(ibtm_pkg::AXES - 1)) begin
            busy <= 1'b0;
          end else begin
            axis <= axis + 1'b1;
            ld   <= 1'b1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire
